/* rtl/bcd_pkg.sv */
// Shared types and constants for the block chunk deframer.
// Holds the parse phase and result kind codes and the result queue word layout.
// No dependencies.
package bcd_pkg;

    localparam int HEADER_BYTES    = 24;
    localparam int LEN_FIELD_BYTES = 4;
    localparam logic [31:0] FIRST_BLOCK_RESET = 32'd32768;
    localparam logic [31:0] COUNT_MAX         = 32'hFFFF_FFFF;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_CLEN_HI = 3'd1,
        PH_CLEN_LO = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_SKIP    = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_FINISH  = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [31:0] total;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

/* rtl/bcd_result_queue.sv */
// Small result queue that takes up to two result words per cycle and hands out one.
// Depends on bcd_pkg for the result word layout and the queue depth.
module bcd_result_queue
    import bcd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output result_t head,
    output logic    not_empty,
    output logic    almost_full
);

    result_t             mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic [QPTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
    assign head         = mem[rd_ptr_reg];
    assign not_empty    = (count_reg != '0);
    assign almost_full  = (count_reg > QCNT_W'(QDEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.num);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push.num) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/block_chunk_deframer.sv */
// Block chunk deframer: parses chained blocks of length-prefixed chunks, one byte per cycle
// while in_stall is low. A byte's results enter the result queue when the byte is accepted.
// Throughput: one input word per cycle, set by the parse step and the result queue;
// in_stall holds input while the queue is almost full; a byte's two results drain in turn.
// Reset clears all parse state and the queue; the first block length resets to 32768.
// Depends on bcd_pkg and bcd_result_queue.
module block_chunk_deframer
    import bcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  payload_byte,
    output logic [31:0] total_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    phase_t      phase_reg,     phase_next;
    logic [31:0] offset_reg,    offset_next;
    logic [31:0] blen_reg,      blen_next;
    logic [31:0] next_len_reg,  next_len_next;
    logic [15:0] chunk_rem_reg, chunk_rem_next;
    logic [7:0]  chunk_hi_reg,  chunk_hi_next;
    logic [31:0] count_reg,     count_next;
    logic        started_reg,   started_next;

    phase_t      ph;
    logic        step;
    logic        eob;
    logic        pay;
    logic        tail;
    kind_t       tail_kind;
    push_t       push;
    result_t     head;
    logic        almost_full;
    logic        pop;
    result_t     pay_word;
    result_t     tail_word;

    assign cfg_ready    = 1'b1;
    assign in_stall     = almost_full;
    assign pop          = out_valid && !out_stall;
    assign result_kind  = head.kind;
    assign payload_byte = head.data;
    assign total_bytes  = head.total;
    assign step = in_valid && !in_stall && (phase_reg != PH_DONE) && (phase_reg != PH_ERROR);
    assign eob  = ({1'b0, offset_reg} + 33'd1) >= {1'b0, blen_reg};

    always_comb
    begin
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        blen_next      = blen_reg;
        next_len_next  = next_len_reg;
        chunk_rem_next = chunk_rem_reg;
        chunk_hi_next  = chunk_hi_reg;
        count_next     = count_reg;
        started_next   = started_reg;
        ph             = phase_reg;
        pay            = 1'b0;
        tail           = 1'b0;
        tail_kind      = KIND_FINISH;

        if (cfg_valid && cfg_ready && !started_reg)
        begin
            blen_next = cfg_data;
        end

        if (step)
        begin
            started_next = 1'b1;
            case (phase_reg)
                PH_HEADER:
                begin
                    if (offset_reg < 32'(LEN_FIELD_BYTES))
                    begin
                        next_len_next = {next_len_reg[23:0], in_byte};
                    end
                    if (offset_reg >= 32'(HEADER_BYTES - 1))
                    begin
                        ph = PH_CLEN_HI;
                    end
                end
                PH_CLEN_HI:
                begin
                    chunk_hi_next = in_byte;
                    ph = PH_CLEN_LO;
                end
                PH_CLEN_LO:
                begin
                    chunk_rem_next = {chunk_hi_reg, in_byte};
                    ph = ({chunk_hi_reg, in_byte} == 16'd0) ? PH_SKIP : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + 32'd1;
                    end
                    pay = 1'b1;
                    chunk_rem_next = chunk_rem_reg - 16'd1;
                    if (chunk_rem_reg == 16'd1)
                    begin
                        ph = PH_CLEN_HI;
                    end
                end
                default:
                begin
                end
            endcase
            phase_next = ph;

            if (eob)
            begin
                if (ph != PH_SKIP)
                begin
                    phase_next = PH_ERROR;
                    tail       = 1'b1;
                    tail_kind  = KIND_ERROR;
                end
                else if (next_len_next == 32'd0)
                begin
                    phase_next = PH_DONE;
                    tail       = 1'b1;
                    tail_kind  = KIND_FINISH;
                end
                else
                begin
                    blen_next      = next_len_next;
                    next_len_next  = 32'd0;
                    offset_next    = 32'd0;
                    chunk_rem_next = 16'd0;
                    chunk_hi_next  = 8'd0;
                    phase_next     = PH_HEADER;
                end
            end
            else
            begin
                offset_next = offset_reg + 32'd1;
            end

            if (in_last && !tail)
            begin
                phase_next = PH_DONE;
                tail       = 1'b1;
                tail_kind  = KIND_FINISH;
            end
        end
    end

    always_comb
    begin
        pay_word.kind   = KIND_PAYLOAD;
        pay_word.data   = in_byte;
        pay_word.total  = count_next;
        tail_word.kind  = tail_kind;
        tail_word.data  = 8'd0;
        tail_word.total = count_next;
        push.num        = 2'(pay) + 2'(tail);
        push.first      = pay ? pay_word : tail_word;
        push.second     = tail_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            offset_reg    <= 32'd0;
            blen_reg      <= FIRST_BLOCK_RESET;
            next_len_reg  <= 32'd0;
            chunk_rem_reg <= 16'd0;
            chunk_hi_reg  <= 8'd0;
            count_reg     <= 32'd0;
            started_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            offset_reg    <= offset_next;
            blen_reg      <= blen_next;
            next_len_reg  <= next_len_next;
            chunk_rem_reg <= chunk_rem_next;
            chunk_hi_reg  <= chunk_hi_next;
            count_reg     <= count_next;
            started_reg   <= started_next;
        end
    end

    bcd_result_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .pop         (pop),
        .head        (head),
        .not_empty   (out_valid),
        .almost_full (almost_full)
    );

endmodule

/* test/block_chunk_deframer_tb.sv */
// Testbench for block_chunk_deframer: sends one chained block stream with random chunk
// layouts, tracks the deframing in a local predictor and checks every result word.
// Depends on bcd_pkg and the block_chunk_deframer RTL.
`timescale 1ns / 100ps

module block_chunk_deframer_tb;
    import bcd_pkg::*;

    localparam int unsigned TARGET_BYTES = 650;
    localparam int unsigned CFG_SPACING  = 150;
    localparam int unsigned OPENING_LEN  = 38;
    localparam int unsigned MIN_BLOCK    = HEADER_BYTES + 2;
    localparam int unsigned STUCK_LIMIT  = 4000;

    typedef enum logic [2:0] {
        END_FINISH,
        END_LAST,
        END_OVERRUN,
        END_SHORT,
        END_UNBOUNDED
    } ending_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } stream_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [31:0] total_bytes;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'h0;

    stream_byte_t pending_words[$];
    result_t      due_results[$];
    stream_byte_t next_word;
    result_t      want;
    int unsigned  words_queued = 0;
    int unsigned  words_taken = 0;
    int unsigned  failures = 0;
    int unsigned  in_hold = 0;
    int unsigned  out_hold = 0;
    int unsigned  stuck_cycles = 0;
    logic         quiet = 1'b0;

    phase_t      trk_phase = PH_HEADER;
    logic [31:0] trk_offset = 32'h0;
    logic [31:0] trk_block_len = FIRST_BLOCK_RESET;
    logic [31:0] trk_next_len = 32'h0;
    logic [15:0] trk_chunk_left = 16'h0;
    logic [7:0]  trk_len_hi = 8'h0;
    logic [31:0] trk_total = 32'h0;
    logic        trk_started = 1'b0;

    block_chunk_deframer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .payload_byte (payload_byte),
        .total_bytes  (total_bytes),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_block_len();
        if ($urandom_range(0, 7) == 0)
        begin
            return MIN_BLOCK;
        end
        return $urandom_range(MIN_BLOCK + 1, 90);
    endfunction

    task automatic add_result(input kind_t kind, input logic [7:0] data);
        result_t r;
        r.kind  = kind;
        r.data  = data;
        r.total = trk_total;
        due_results.push_back(r);
    endtask

    // Advances the tracked parse state by one accepted word.
    task automatic deframe(input logic [7:0] b, input logic eos);
        logic block_end;
        if (trk_phase != PH_DONE && trk_phase != PH_ERROR)
        begin
            trk_started = 1'b1;
            block_end = ({1'b0, trk_offset} + 33'd1) >= {1'b0, trk_block_len};
            case (trk_phase)
                PH_HEADER:
                begin
                    if (trk_offset < LEN_FIELD_BYTES)
                    begin
                        trk_next_len = {trk_next_len[23:0], b};
                    end
                    if (({1'b0, trk_offset} + 33'd1) >= HEADER_BYTES)
                    begin
                        trk_phase = PH_CLEN_HI;
                    end
                end
                PH_CLEN_HI:
                begin
                    trk_len_hi = b;
                    trk_phase = PH_CLEN_LO;
                end
                PH_CLEN_LO:
                begin
                    trk_chunk_left = {trk_len_hi, b};
                    trk_phase = (trk_chunk_left == 16'h0) ? PH_SKIP : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (trk_total != COUNT_MAX)
                    begin
                        trk_total = trk_total + 32'd1;
                    end
                    add_result(KIND_PAYLOAD, b);
                    trk_chunk_left = trk_chunk_left - 16'd1;
                    if (trk_chunk_left == 16'h0)
                    begin
                        trk_phase = PH_CLEN_HI;
                    end
                end
                default:
                begin
                end
            endcase
            if (block_end)
            begin
                if (trk_phase != PH_SKIP)
                begin
                    trk_phase = PH_ERROR;
                    add_result(KIND_ERROR, 8'h00);
                end
                else if (trk_next_len == 32'h0)
                begin
                    trk_phase = PH_DONE;
                    add_result(KIND_FINISH, 8'h00);
                end
                else
                begin
                    trk_block_len = trk_next_len;
                    trk_next_len = 32'h0;
                    trk_offset = 32'h0;
                    trk_chunk_left = 16'h0;
                    trk_len_hi = 8'h0;
                    trk_phase = PH_HEADER;
                end
            end
            else
            begin
                trk_offset = trk_offset + 32'd1;
            end
            if (eos && trk_phase != PH_DONE && trk_phase != PH_ERROR)
            begin
                trk_phase = PH_DONE;
                add_result(KIND_FINISH, 8'h00);
            end
        end
    endtask

    task automatic put_byte(input logic [7:0] b, input logic eos = 1'b0);
        stream_byte_t w;
        w.data = b;
        w.eos  = eos;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic mark_final();
        stream_byte_t w;
        w = pending_words.pop_back();
        w.eos = 1'b1;
        pending_words.push_back(w);
    endtask

    task automatic put_header(input logic [31:0] next_len);
        put_byte(next_len[31:24]);
        put_byte(next_len[23:16]);
        put_byte(next_len[15:8]);
        put_byte(next_len[7:0]);
        repeat (HEADER_BYTES - LEN_FIELD_BYTES) put_byte(8'($urandom));
    endtask

    task automatic put_chunk(input int unsigned len);
        put_byte(len[15:8]);
        put_byte(len[7:0]);
        repeat (len) put_byte(8'($urandom));
    endtask

    // Well-formed block: header, chunks that fit, a zero length, then filler.
    task automatic put_block(input logic [31:0] len, input logic [31:0] next_len);
        int unsigned rem;
        int unsigned c;
        put_header(next_len);
        rem = len - HEADER_BYTES;
        while (rem >= 5 && $urandom_range(0, 3) != 0)
        begin
            c = $urandom_range(1, (rem - 4 > 40) ? 40 : rem - 4);
            put_chunk(c);
            rem -= c + 2;
        end
        put_byte(8'h00);
        put_byte(8'h00);
        repeat (rem - 2) put_byte(8'($urandom));
    endtask

    // Stream cut off by the last flag, either inside a chunk or in the filler.
    task automatic put_tail();
        int unsigned c;
        int unsigned k;
        if ($urandom_range(0, 1) != 0)
        begin
            c = $urandom_range(1, 16'hFFFF);
            k = $urandom_range(0, (c < 30) ? c : 30);
            put_byte(c[15:8]);
            put_byte(c[7:0]);
            repeat (k) put_byte(8'($urandom));
        end
        else
        begin
            put_byte(8'h00);
            put_byte(8'h00);
            repeat ($urandom_range(0, 8)) put_byte(8'($urandom));
        end
        mark_final();
    endtask

    task automatic wait_idle();
        while (words_taken != words_queued || due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_first_size(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (!trk_started)
        begin
            trk_block_len = value;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic reconfigure();
        int unsigned r;
        wait_idle();
        r = $urandom_range(0, 2);
        if (r == 0)
        begin
            write_first_size(HEADER_BYTES);
        end
        else if (r == 1)
        begin
            write_first_size(32'hFFFF_FFFF);
        end
        else
        begin
            write_first_size($urandom);
        end
        quiet = ($urandom_range(0, 2) == 0);
    endtask

    always @(posedge clk)
    begin : driver
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                deframe(in_byte, in_last);
                words_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_hold != 0 || pending_words.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (in_hold != 0)
                    begin
                        in_hold--;
                    end
                end
                else
                begin
                    next_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    in_byte <= next_word.data;
                    in_last <= next_word.eos;
                    in_hold = quiet ? 0 : gap_len();
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result, kind %0d byte %h total %0d",
                             $time, result_kind, payload_byte, total_bytes);
                    failures++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result_kind !== want.kind)
                    begin
                        $display("%0t: result_kind expected %0d, got %0d",
                                 $time, want.kind, result_kind);
                        failures++;
                    end
                    if (payload_byte !== want.data)
                    begin
                        $display("%0t: payload_byte expected %h, got %h",
                                 $time, want.data, payload_byte);
                        failures++;
                    end
                    if (total_bytes !== want.total)
                    begin
                        $display("%0t: total_bytes expected %0d, got %0d",
                                 $time, want.total, total_bytes);
                        failures++;
                    end
                end
            end
            if (out_hold != 0)
            begin
                out_stall <= 1'b1;
                out_hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 3) == 0)
                begin
                    out_hold = gap_len();
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            begin
                stuck_cycles <= 0;
            end
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("block_chunk_deframer test failed");
                $finish;
            end
            else
            begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        ending_t     ending;
        logic [31:0] cur_len;
        logic [31:0] next_len;
        int unsigned rem;
        int unsigned c;
        int unsigned next_cfg;
        ending = ending_t'($urandom_range(0, 4));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_first_size(32'hFFFF_FFFF);
        write_first_size(HEADER_BYTES);
        write_first_size((ending == END_UNBOUNDED) ? 32'hFFFF_FFFF : OPENING_LEN);

        // Opening block: extreme header bytes, one-word chunks of 0xFF and 0x00, then a two-word chunk.
        next_len = pick_block_len();
        put_byte(next_len[31:24]);
        put_byte(next_len[23:16]);
        put_byte(next_len[15:8]);
        put_byte(next_len[7:0]);
        for (int i = 0; i < HEADER_BYTES - LEN_FIELD_BYTES; i++)
        begin
            put_byte(i[0] ? 8'hFF : 8'h00);
        end
        put_byte(8'h00);
        put_byte(8'h01);
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'h01);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h02);
        put_byte(8'h55);
        put_byte(8'hAA);
        next_cfg = words_queued + CFG_SPACING;

        if (ending != END_UNBOUNDED)
        begin
            put_byte(8'h00);
            put_byte(8'h00);
            put_byte(8'hFF);
            put_byte(8'h00);
            cur_len = next_len;
            while (words_queued < TARGET_BYTES)
            begin
                if (words_queued + cur_len >= TARGET_BYTES)
                begin
                    case (ending)
                        END_LAST:
                        begin
                            next_len = $urandom_range(100, 32'hFFFF_FFFF);
                        end
                        END_SHORT:
                        begin
                            next_len = $urandom_range(1, HEADER_BYTES - 1);
                        end
                        default:
                        begin
                            next_len = pick_block_len();
                        end
                    endcase
                end
                else
                begin
                    next_len = pick_block_len();
                end
                put_block(cur_len, next_len);
                cur_len = next_len;
                if (words_queued >= next_cfg)
                begin
                    reconfigure();
                    next_cfg = words_queued + CFG_SPACING;
                end
            end
            case (ending)
                END_FINISH:
                begin
                    put_block(cur_len, 32'h0);
                    if ($urandom_range(0, 1) != 0)
                    begin
                        mark_final();
                    end
                end
                END_LAST:
                begin
                    put_header(pick_block_len());
                    put_tail();
                end
                END_OVERRUN:
                begin
                    put_header(pick_block_len());
                    rem = cur_len - HEADER_BYTES;
                    while (rem >= 5 && $urandom_range(0, 2) != 0)
                    begin
                        c = $urandom_range(1, (rem - 4 > 40) ? 40 : rem - 4);
                        put_chunk(c);
                        rem -= c + 2;
                    end
                    c = $urandom_range((rem > 2) ? rem - 2 : 1, 16'hFFFF);
                    put_byte(c[15:8]);
                    put_byte(c[7:0]);
                    repeat (rem - 2) put_byte(8'($urandom));
                end
                default:
                begin
                    // The block ends before its header is complete.
                    repeat (cur_len) put_byte(8'($urandom));
                end
            endcase
        end
        else
        begin
            while (words_queued < TARGET_BYTES)
            begin
                put_chunk($urandom_range(1, 40));
                if (words_queued >= next_cfg)
                begin
                    reconfigure();
                    next_cfg = words_queued + CFG_SPACING;
                end
            end
            put_tail();
        end

        // Words after the stream has ended must be dropped.
        repeat ($urandom_range(2, 8)) put_byte(8'($urandom), 1'($urandom_range(0, 1)));

        wait_idle();
        repeat (10) @(posedge clk);
        if (failures == 0)
        begin
            $display("block_chunk_deframer test passed");
        end
        else
        begin
            $display("block_chunk_deframer test failed");
        end
        $finish;
    end

endmodule
